FILE: rtl/c16f_pkg.sv
// Shared constants and types for the CRC-16/MODBUS packet framer.
// No dependencies; used by c16f_crc_fold and crc16_modbus_packet_framer.
package c16f_pkg;

    // CRC-16/MODBUS: reflected polynomial, all-ones start, no final xor
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // frame header and trailer bytes
    localparam logic [7:0] HDR0 = 8'h66;
    localparam logic [7:0] HDR1 = 8'h68;
    localparam logic [7:0] TRL0 = 8'h5B;
    localparam logic [7:0] TRL1 = 8'h81;

    // length byte carries payload length plus the two CRC bytes
    localparam logic [7:0] LEN_ADJ = 8'd2;

    // position of the next byte to send within one input beat's output
    localparam logic [2:0] PH_HDR0   = 3'd0;
    localparam logic [2:0] PH_HDR1   = 3'd1;
    localparam logic [2:0] PH_LEN    = 3'd2;
    localparam logic [2:0] PH_BYTE   = 3'd3;
    localparam logic [2:0] PH_CRC_LO = 3'd4;
    localparam logic [2:0] PH_CRC_HI = 3'd5;
    localparam logic [2:0] PH_TRL0   = 3'd6;
    localparam logic [2:0] PH_TRL1   = 3'd7;

    // one accepted beat, held while its bytes are sent
    typedef struct packed {
        logic [7:0]  data;
        logic [7:0]  len_byte;
        logic [15:0] crc;
        logic        has_tail;
    } item_t;

endpackage

FILE: rtl/c16f_crc_fold.sv
// Folds one byte into a CRC-16/MODBUS register, bit by bit, LSB first.
// Depends on c16f_pkg for the polynomial.
module c16f_crc_fold (
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [15:0] crc_out
);

    // eight shift/xor steps of the reflected CRC
    always_comb begin
        logic [15:0] c;
        c = crc_in ^ {8'd0, data_in};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ c16f_pkg::CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

FILE: rtl/crc16_modbus_packet_framer.sv
// CRC-16/MODBUS packet framer: payload beats in, framed byte stream out.
// An accepted beat waits in the item slot; its bytes leave one per cycle
// through the output byte register while the sink is ready, which sets
// this rate. A beat gives 1 byte, plus 3 on a packet's first beat (header)
// and 4 on its last (CRC and trailer). Reset (aresetn low, synchronous)
// empties both stages, clears in_frame and loads the CRC with 0xFFFF.
module crc16_modbus_packet_framer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_payload_byte,
    input  logic [7:0] s_payload_len,
    input  logic       s_last_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_frame_end
);

    logic                 in_frame_reg, in_frame_next;
    logic [15:0]          crc_reg, crc_next;
    logic                 item_valid_reg, item_valid_next;
    c16f_pkg::item_t      item_reg, item_next;
    logic [2:0]           phase_reg, phase_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_byte_reg, out_byte_next;
    logic                 out_end_reg, out_end_next;

    logic [15:0]          crc_base;
    logic [15:0]          crc_folded;
    logic                 accept;
    logic                 load_out;
    logic                 item_done;
    logic [7:0]           sel_byte;

    // CRC of the packet so far, restarted on a packet's first beat
    assign crc_base = in_frame_reg ? crc_reg : c16f_pkg::CRC_INIT;

    c16f_crc_fold u_fold (
        .crc_in  (crc_base),
        .data_in (s_payload_byte),
        .crc_out (crc_folded)
    );

    // handshake between the item slot and the output register
    assign item_done = (phase_reg == c16f_pkg::PH_TRL1) ||
                       ((phase_reg == c16f_pkg::PH_BYTE) && !item_reg.has_tail);
    assign load_out  = item_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !item_valid_reg || (load_out && item_done);
    assign accept    = s_valid && s_ready;

    // byte selected for the current phase
    always_comb begin
        unique case (phase_reg)
            c16f_pkg::PH_HDR0:   sel_byte = c16f_pkg::HDR0;
            c16f_pkg::PH_HDR1:   sel_byte = c16f_pkg::HDR1;
            c16f_pkg::PH_LEN:    sel_byte = item_reg.len_byte;
            c16f_pkg::PH_BYTE:   sel_byte = item_reg.data;
            c16f_pkg::PH_CRC_LO: sel_byte = item_reg.crc[7:0];
            c16f_pkg::PH_CRC_HI: sel_byte = item_reg.crc[15:8];
            c16f_pkg::PH_TRL0:   sel_byte = c16f_pkg::TRL0;
            c16f_pkg::PH_TRL1:   sel_byte = c16f_pkg::TRL1;
        endcase
    end

    // next-state logic
    always_comb begin
        in_frame_next   = in_frame_reg;
        crc_next        = crc_reg;
        item_valid_next = item_valid_reg;
        item_next       = item_reg;
        phase_next      = phase_reg;
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        out_end_next    = out_end_reg;

        // item slot: take a new beat or step through the current one
        if (accept) begin
            item_valid_next    = 1'b1;
            item_next.data     = s_payload_byte;
            item_next.len_byte = s_payload_len + c16f_pkg::LEN_ADJ;
            item_next.crc      = crc_folded;
            item_next.has_tail = s_last_byte;
            phase_next         = in_frame_reg ? c16f_pkg::PH_BYTE : c16f_pkg::PH_HDR0;
            in_frame_next      = !s_last_byte;
            crc_next           = s_last_byte ? c16f_pkg::CRC_INIT : crc_folded;
        end else if (load_out) begin
            if (item_done) begin
                item_valid_next = 1'b0;
            end else begin
                phase_next = phase_reg + 3'd1;
            end
        end

        // output register
        if (load_out) begin
            out_valid_next = 1'b1;
            out_byte_next  = sel_byte;
            out_end_next   = (phase_reg == c16f_pkg::PH_TRL1);
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // registers: control cleared on reset, payload free-running
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg   <= 1'b0;
            crc_reg        <= c16f_pkg::CRC_INIT;
            item_valid_reg <= 1'b0;
            phase_reg      <= c16f_pkg::PH_HDR0;
            out_valid_reg  <= 1'b0;
        end else begin
            in_frame_reg   <= in_frame_next;
            crc_reg        <= crc_next;
            item_valid_reg <= item_valid_next;
            phase_reg      <= phase_next;
            out_valid_reg  <= out_valid_next;
        end
        item_reg     <= item_next;
        out_byte_reg <= out_byte_next;
        out_end_reg  <= out_end_next;
    end

    assign m_valid     = out_valid_reg;
    assign m_out_byte  = out_byte_reg;
    assign m_frame_end = out_end_reg;

    // checks
    a_end_is_trailer: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_end |-> m_out_byte == c16f_pkg::TRL1)
        else $error("frame_end on a byte other than the trailer");

    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_last_byte |=> !in_frame_reg && crc_reg == c16f_pkg::CRC_INIT)
        else $error("CRC or frame flag not restarted after last beat");

    a_no_tail_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid_reg && !item_reg.has_tail |-> phase_reg <= c16f_pkg::PH_BYTE)
        else $error("tail phase reached on a beat without tail");

    a_ready_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready && item_valid_reg |-> load_out && item_done)
        else $error("new beat taken while current beat still has bytes");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// Testbench for crc16_modbus_packet_framer: drives payload beats and checks the framed stream.
// Needs c16f_pkg and the framer RTL. Expected bytes come from an in-bench CRC-16/MODBUS model.
module tb;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_BEATS = 115;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } frame_byte_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_payload_byte = 8'h00;
    logic [7:0] s_payload_len = 8'h00;
    logic       s_last_byte = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_frame_end;

    // expected framed bytes, oldest first
    frame_byte_t frame_bytes_q[$];

    // model state of the framer
    logic        pkt_open = 1'b0;
    logic [15:0] pkt_crc = c16f_pkg::CRC_INIT;

    int  err_count = 0;
    int  stall_cycles = 0;
    int  hold_seq = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;

    crc16_modbus_packet_framer DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_payload_byte(s_payload_byte),
        .s_payload_len (s_payload_len),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_frame_end   (m_frame_end)
    );

    always #4 aclk = ~aclk;

    // bitwise CRC-16/MODBUS update, LSB first
    function automatic logic [15:0] crc16_fold_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ c16f_pkg::CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic fe);
        frame_byte_t fb;
        fb.out_byte = b;
        fb.frame_end = fe;
        frame_bytes_q.insert(frame_bytes_q.size(), fb);
    endtask

    // work out the framed bytes one accepted beat produces
    task automatic frame_predict(input logic [7:0] b, input logic [7:0] len, input logic last);
        if (!pkt_open) begin
            pkt_crc = c16f_pkg::CRC_INIT;
            push_byte(c16f_pkg::HDR0, 1'b0);
            push_byte(c16f_pkg::HDR1, 1'b0);
            push_byte(len + c16f_pkg::LEN_ADJ, 1'b0);
            pkt_open = 1'b1;
        end
        push_byte(b, 1'b0);
        pkt_crc = crc16_fold_byte(pkt_crc, b);
        if (last) begin
            push_byte(pkt_crc[7:0], 1'b0);
            push_byte(pkt_crc[15:8], 1'b0);
            push_byte(c16f_pkg::TRL0, 1'b0);
            push_byte(c16f_pkg::TRL1, 1'b1);
            pkt_open = 1'b0;
            pkt_crc = c16f_pkg::CRC_INIT;
        end
    endtask

    // offer one beat, wait for it to be taken, then record what it should produce
    task automatic send_beat(input logic [7:0] b, input logic [7:0] len, input logic last);
        int gap;
        gap = 0;
        if (tx_idle_on)
            while ($urandom_range(99) < 23) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_payload_byte <= b;
        s_payload_len  <= len;
        s_last_byte    <= last;
        do @(posedge aclk); while (!s_ready);
        frame_predict(b, len, last);
    endtask

    // one packet of n random bytes; length field only matters on the first beat
    task automatic send_packet(input int n, input logic [7:0] len_field);
        for (int i = 0; i < n; i++)
            send_beat(8'($urandom_range(255)),
                      (i == 0) ? len_field : 8'($urandom_range(255)),
                      i == n - 1);
    endtask

    task automatic test_directed();
        logic [7:0] digits[9];
        digits = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
        // single-byte packets at the byte and length extremes
        send_beat(8'h00, 8'd1, 1'b1);
        send_beat(8'hFF, 8'd253, 1'b1);
        // length wrap: 254 -> 0, 255 -> 1, 0 -> 2
        send_beat(8'hAA, 8'd254, 1'b0);
        send_beat(8'h55, 8'h00, 1'b1);
        send_beat(8'h01, 8'd255, 1'b1);
        send_beat(8'h80, 8'd0, 1'b1);
        // check string, CRC 0x4B37
        for (int i = 0; i < 9; i++)
            send_beat(digits[i], (i == 0) ? 8'd9 : 8'hFF, i == 8);
        // length field disagreeing with the beats sent
        send_beat(8'h7F, 8'd5, 1'b0);
        send_beat(8'hFE, 8'd1, 1'b1);
        send_beat(8'h12, 8'd1, 1'b0);
        send_beat(8'h34, 8'd200, 1'b0);
        send_beat(8'hC3, 8'd7, 1'b0);
        send_beat(8'h3C, 8'd1, 1'b1);
    endtask

    // back-to-back beats with the sink always ready
    task automatic test_no_idle();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        for (int p = 0; p < 6; p++) begin
            int n;
            n = $urandom_range(1, 6);
            send_packet(n, 8'(n));
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // sink holds off while the source keeps offering, so the input stalls
    task automatic test_backpressure();
        hold_seq++;
        send_packet(24, 8'd24);
    endtask

    task automatic test_random();
        int beats;
        beats = 0;
        while (beats < RANDOM_BEATS) begin
            int n;
            logic [7:0] len_field;
            n = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            // mostly an honest length, sometimes any value
            len_field = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'(n);
            send_packet(n, len_field);
            beats += n;
        end
    endtask

    // sink side: random ready, plus a long hold-off on request
    initial begin
        int hold_left;
        int seen;
        hold_left = 0;
        seen = 0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (hold_seq != seen) begin
                seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!rx_idle_on) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 23);
            end
        end
    end

    // compare each output beat with the oldest expected byte
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (frame_bytes_q.size() == 0) begin
                $display("%0t: unexpected output beat, got byte %02h end %0b",
                         $time, m_out_byte, m_frame_end);
                err_count++;
            end else begin
                frame_byte_t fb;
                fb = frame_bytes_q.pop_front();
                if (m_out_byte !== fb.out_byte) begin
                    $display("%0t: out_byte expected %02h got %02h",
                             $time, fb.out_byte, m_out_byte);
                    err_count++;
                end
                if (m_frame_end !== fb.frame_end) begin
                    $display("%0t: frame_end expected %0b got %0b",
                             $time, fb.frame_end, m_frame_end);
                    err_count++;
                end
            end
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("** crc16_modbus_packet_framer: FAILED **");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_no_idle();
        test_backpressure();
        test_random();
        // last beat was taken at this edge; stop offering at once
        s_valid <= 1'b0;
        while (frame_bytes_q.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (err_count == 0 && frame_bytes_q.size() == 0) begin
            $display("** crc16_modbus_packet_framer: PASSED **");
        end else begin
            $display("** crc16_modbus_packet_framer: FAILED **");
        end
        $finish;
    end

endmodule
